@@ rtl/servo_neck_easing_mixer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the servo neck easing mixer
// Clocked checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERVO_NECK_EASING_MIXER_ASSERT_SVH
`define SERVO_NECK_EASING_MIXER_ASSERT_SVH

// same-cycle implication
`define SNEM_CHECK(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("servo mixer check failed");

// next-cycle implication
`define SNEM_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("servo mixer check failed");

`endif

@@ rtl/snem_pkg.sv @@
// ----------------------------------------------------------------------------
// snem_pkg
// Shared types, constants and helpers of the servo neck easing mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package snem_pkg;

	localparam int DIV_QW     = 24;
	localparam int DIV_DW     = 17;
	localparam int DIV_CW     = 5;
	localparam int FRAC_STEPS = 16;
	localparam int MAP_STEPS  = 24;

	localparam int FWD_LIMIT_LOW   = 0;
	localparam int FWD_LIMIT_HIGH  = 200;
	localparam int SIDE_LIMIT_LOW  = -100;
	localparam int SIDE_LIMIT_HIGH = 100;
	localparam int FWD_BIAS        = 100;
	localparam int SIDE_OUT_LOW    = -50;
	localparam int SIDE_OUT_HIGH   = 50;
	localparam int ROT_OUT_HIGH    = 110;
	localparam int TILT_IN_HIGH    = 200;
	localparam int LEFT_HIGH       = 65;
	localparam int LEFT_LOW        = 10;
	localparam int RIGHT_LOW       = 35;
	localparam int RIGHT_HIGH      = 90;
	localparam int NECK_HIGH       = 100;
	localparam int SERVO_FULL      = 180;
	localparam int ONE_Q16         = 65536;
	localparam int HALF_Q16        = 32768;
	localparam int SIDE_STEP_Q16   = 3932;

	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] rem_init;
		logic [DIV_QW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
		logic [DIV_CW-1:0] steps;
	} div_req_t;

	// Q11.8 to whole degrees, truncated toward zero
	function automatic logic signed [10:0] q8_int(input logic signed [18:0] v);
		logic signed [18:0] adj;
		adj = v[18] ? v + 19'sd255 : v;
		return $signed(adj[18:8]);
	endfunction

endpackage

`default_nettype wire

@@ rtl/snem_div.sv @@
// ----------------------------------------------------------------------------
// snem_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module snem_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire snem_pkg::div_req_t            req,
	output logic                               busy,
	output logic                               done,
	output logic [snem_pkg::DIV_QW-1:0]        quo
);

	logic [snem_pkg::DIV_DW-1:0] rem_q;
	logic [snem_pkg::DIV_DW-1:0] div_q;
	logic [snem_pkg::DIV_QW-1:0] quo_q;
	logic [snem_pkg::DIV_CW-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [snem_pkg::DIV_DW:0]   remsh;
	logic                        ge;

	assign remsh = {rem_q, quo_q[snem_pkg::DIV_QW-1]};
	assign ge    = remsh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			div_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			rem_q  <= req.rem_init;
			div_q  <= req.divisor;
			quo_q  <= req.dividend;
			cnt_q  <= req.steps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? snem_pkg::DIV_DW'(remsh - {1'b0, div_q})
			            : remsh[snem_pkg::DIV_DW-1:0];
			quo_q <= {quo_q[snem_pkg::DIV_QW-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == snem_pkg::DIV_CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

@@ rtl/servo_neck_easing_mixer.sv @@
// ----------------------------------------------------------------------------
// servo_neck_easing_mixer
// Eased head rotation and neck tilt trajectories mixed into servo pulses.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tuser: command; tdata: angle, move_time, now_ms
//  m_*      | out       | tuser: servo; tdata: pulse; tlast: final pulse of a tick
//  cfg_*    | in        | register writes, index 0..6
//
//  Rotation and forward set commands return from S_SET to idle, while a sideways
//  set runs a range map first. In a tick, rotation and forward tilt each need
//  one 16-step divide while still inside their span, each of the three or
//  four pulses two 24-step divides, all on the one bit-serial divider and one
//  20x18 multiplier.
//  Reset loads the register defaults and clears all trajectory state.
//  A stalled output holds the sequencer at its next pulse; input is taken
//  only between items.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_neck_easing_mixer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // angle[8:0], move_time[24:9], now_ms[56:25]
	input  wire logic [1:0]  s_tuser,   // command[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // pulse[11:0]
	output logic [1:0]       m_tuser,   // servo[1:0]
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [11:0] cfg_wdata
);

	`include "servo_neck_easing_mixer_assert.svh"

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SET   = 4'd1;
	localparam logic [3:0] S_PICK  = 4'd2;
	localparam logic [3:0] S_FRAC  = 4'd3;
	localparam logic [3:0] S_FDIV  = 4'd4;
	localparam logic [3:0] S_SQ    = 4'd5;
	localparam logic [3:0] S_EASE  = 4'd6;
	localparam logic [3:0] S_PROD  = 4'd7;
	localparam logic [3:0] S_UPD   = 4'd8;
	localparam logic [3:0] S_MMUL  = 4'd9;
	localparam logic [3:0] S_MDIV  = 4'd10;
	localparam logic [3:0] S_MWAIT = 4'd11;
	localparam logic [3:0] S_MDONE = 4'd12;
	localparam logic [3:0] S_EMIT  = 4'd13;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_ROT  = 2'd1;
	localparam logic [1:0] CMD_FWD  = 2'd2;
	localparam logic [1:0] CMD_SIDE = 2'd3;

	localparam logic [1:0] SRV_ROT   = 2'd0;
	localparam logic [1:0] SRV_LEFT  = 2'd1;
	localparam logic [1:0] SRV_RIGHT = 2'd2;
	localparam logic [1:0] SRV_NECK  = 2'd3;

	localparam logic [1:0] CH_ROT  = 2'd0;
	localparam logic [1:0] CH_FWD  = 2'd1;
	localparam logic [1:0] CH_SIDE = 2'd2;

	localparam logic [2:0] MAP_ROT   = 3'd0;
	localparam logic [2:0] MAP_LEFT  = 3'd1;
	localparam logic [2:0] MAP_RIGHT = 3'd2;
	localparam logic [2:0] MAP_NECK  = 3'd3;
	localparam logic [2:0] MAP_PULSE = 3'd4;
	localparam logic [2:0] MAP_SIDE  = 3'd5;

	localparam logic [2:0] REG_PULSE_MIN = 3'd0;
	localparam logic [2:0] REG_PULSE_MAX = 3'd1;
	localparam logic [2:0] REG_ROT_MIN   = 3'd2;
	localparam logic [2:0] REG_ROT_MAX   = 3'd3;
	localparam logic [2:0] REG_ROT_OFF   = 3'd4;
	localparam logic [2:0] REG_FWD_OFF   = 3'd5;
	localparam logic [2:0] REG_SIDE_OFF  = 3'd6;

	// control
	logic [3:0]         state_q;
	logic [1:0]         cmd_q;
	logic signed [8:0]  ang_q;
	logic [15:0]        mt_q;
	logic [2:0]         mv_q;
	logic               rot_emit_q;
	logic [1:0]         ch_q;
	logic [16:0]        f_q;
	logic [16:0]        e_q;
	logic               up_q;
	logic [1:0]         srv_q;
	logic [2:0]         map_sel_q;
	logic signed [8:0]  deg_q;
	logic signed [25:0] res_q;
	logic               sign_q;

	// configuration
	logic [11:0]        pmin_q, pmax_q;
	logic signed [8:0]  rmin_q, rmax_q;
	logic signed [7:0]  roff_q, foff_q, soff_q;

	// trajectory state
	logic [31:0]        time_now_q;
	logic signed [17:0] rot_start_q, rot_pos_q, rot_goal_q;
	logic [31:0]        rot_begin_q;
	logic [16:0]        rot_span_q;
	logic signed [17:0] fwd_start_q, fwd_pos_q, fwd_goal_q;
	logic [31:0]        fwd_begin_q;
	logic [16:0]        fwd_span_q;
	logic signed [17:0] side_start_q, side_pos_q, side_goal_q;
	logic [16:0]        side_frac_q;

	// output register
	logic               out_valid_q;
	logic [1:0]         out_servo_q;
	logic [11:0]        out_pulse_q;
	logic               out_last_q;

	// shared multiplier
	logic signed [19:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [37:0] mul_q;

	// shared divider
	snem_pkg::div_req_t          div_req;
	logic                        div_busy;
	logic                        div_done;
	logic [snem_pkg::DIV_QW-1:0] div_quo;

	snem_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		mul_q <= 38'(mul_a) * 38'(mul_b);
	end

	logic in_acc, out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// set commands: offset and clamp
	logic signed [9:0]  rsum, rdeg, ssum, sdeg;
	logic signed [10:0] fsum, fdeg;
	logic signed [17:0] rgoal, fgoal;
	logic signed [18:0] rdiff, fdiff;
	logic [18:0]        rabs, fabs;
	logic [16:0]        rspan, fspan;

	assign rsum  = 10'(ang_q) + 10'(roff_q);
	assign rdeg  = (rsum < 10'(rmin_q)) ? 10'(rmin_q) :
	               ((rsum > 10'(rmax_q)) ? 10'(rmax_q) : rsum);
	assign rgoal = $signed({rdeg, 8'd0});
	assign fsum  = 11'(ang_q) + 11'(foff_q) + 11'(snem_pkg::FWD_BIAS);
	assign fdeg  = (fsum < 11'(snem_pkg::FWD_LIMIT_LOW)) ? 11'(snem_pkg::FWD_LIMIT_LOW) :
	               ((fsum > 11'(snem_pkg::FWD_LIMIT_HIGH)) ? 11'(snem_pkg::FWD_LIMIT_HIGH)
	                                                       : fsum);
	assign fgoal = $signed({fdeg[9:0], 8'd0});
	assign ssum  = 10'(ang_q) + 10'(soff_q);
	assign sdeg  = (ssum < 10'(snem_pkg::SIDE_LIMIT_LOW)) ? 10'(snem_pkg::SIDE_LIMIT_LOW) :
	               ((ssum > 10'(snem_pkg::SIDE_LIMIT_HIGH)) ? 10'(snem_pkg::SIDE_LIMIT_HIGH)
	                                                        : ssum);

	assign rdiff = 19'(rgoal) - 19'(rot_pos_q);
	assign fdiff = 19'(fgoal) - 19'(fwd_pos_q);
	assign rabs  = rdiff[18] ? 19'(-rdiff) : 19'(rdiff);
	assign fabs  = fdiff[18] ? 19'(-fdiff) : 19'(fdiff);
	assign rspan = (mt_q != 16'd0) ? {1'b0, mt_q} : 17'(rabs >> 4);
	assign fspan = (mt_q != 16'd0) ? {1'b0, mt_q} : 17'(fabs >> 4);

	// axis under easing
	logic signed [17:0] cur_s, cur_c, cur_g;
	logic [31:0]        cur_begin;
	logic [16:0]        cur_span;

	always_comb begin
		case (ch_q)
			CH_ROT: begin
				cur_s = rot_start_q; cur_c = rot_pos_q; cur_g = rot_goal_q;
				cur_begin = rot_begin_q; cur_span = rot_span_q;
			end
			CH_FWD: begin
				cur_s = fwd_start_q; cur_c = fwd_pos_q; cur_g = fwd_goal_q;
				cur_begin = fwd_begin_q; cur_span = fwd_span_q;
			end
			default: begin
				cur_s = side_start_q; cur_c = side_pos_q; cur_g = side_goal_q;
				cur_begin = '0; cur_span = '0;
			end
		endcase
	end

	logic [31:0] elapsed;
	logic        el_done;
	assign elapsed = time_now_q - cur_begin;
	assign el_done = elapsed >= {15'd0, cur_span};

	// quadratic ease from the squared fraction
	logic [33:0] sq;
	logic [35:0] ease_hi;
	logic [16:0] ease_v;
	assign sq      = mul_q[33:0];
	assign ease_hi = {1'b0, f_q, 18'd0} - {1'b0, sq, 1'b0} - 36'h1_0000_0000;
	assign ease_v  = (f_q < 17'(snem_pkg::HALF_Q16)) ? sq[31:15] : ease_hi[32:16];

	logic               up_c;
	logic signed [18:0] move_dist;
	assign up_c      = cur_c < cur_g;
	assign move_dist = up_c ? 19'(cur_g) - 19'(cur_s) : 19'(cur_s) - 19'(cur_g);

	// truncate the scaled step toward zero
	logic signed [37:0] step_adj;
	logic signed [21:0] step_t;
	logic signed [22:0] new_pos;
	logic signed [17:0] new_pos_cl;
	assign step_adj = mul_q + (mul_q[37] ? 38'sd65535 : 38'sd0);
	assign step_t   = $signed(step_adj[37:16]);
	assign new_pos  = up_q ? 23'(cur_s) + 23'(step_t) : 23'(cur_s) - 23'(step_t);
	assign new_pos_cl = ((up_q && new_pos > 23'(cur_g)) || (!up_q && new_pos < 23'(cur_g)))
	                    ? cur_g : new_pos[17:0];

	logic [17:0] side_frac_sum;
	assign side_frac_sum = 18'(side_frac_q) + 18'(snem_pkg::SIDE_STEP_Q16);

	// range map operands
	logic signed [12:0] mx, mil, mih, mol, moh;
	logic signed [13:0] md, mdx, mdy;
	logic [13:0]        md_abs;
	logic signed [25:0] cl_lo, cl_hi;

	always_comb begin
		mx = '0; mil = '0; mih = '0; mol = '0; moh = '0;
		cl_lo = '0; cl_hi = '0;
		case (map_sel_q)
			MAP_ROT: begin
				mx  = 13'(snem_pkg::q8_int(19'(rot_pos_q)));
				mil = 13'(rmin_q); mih = 13'(rmax_q);
				moh = 13'(snem_pkg::ROT_OUT_HIGH);
				cl_hi = 26'(snem_pkg::SERVO_FULL);
			end
			MAP_LEFT: begin
				mx  = 13'(snem_pkg::q8_int(19'(fwd_pos_q) + 19'(side_pos_q)));
				mih = 13'(snem_pkg::TILT_IN_HIGH);
				mol = 13'(snem_pkg::LEFT_HIGH); moh = 13'(snem_pkg::LEFT_LOW);
				cl_lo = 26'(snem_pkg::LEFT_LOW); cl_hi = 26'(snem_pkg::LEFT_HIGH);
			end
			MAP_RIGHT: begin
				mx  = 13'(snem_pkg::q8_int(19'(fwd_pos_q) - 19'(side_pos_q)));
				mih = 13'(snem_pkg::TILT_IN_HIGH);
				mol = 13'(snem_pkg::RIGHT_LOW); moh = 13'(snem_pkg::RIGHT_HIGH);
				cl_lo = 26'(snem_pkg::RIGHT_LOW); cl_hi = 26'(snem_pkg::RIGHT_HIGH);
			end
			MAP_NECK: begin
				mx  = 13'(snem_pkg::q8_int(19'(fwd_pos_q)));
				mih = 13'(snem_pkg::TILT_IN_HIGH);
				mol = 13'(snem_pkg::NECK_HIGH);
				cl_hi = 26'(snem_pkg::NECK_HIGH);
			end
			MAP_PULSE: begin
				mx  = 13'(deg_q);
				mih = 13'(snem_pkg::SERVO_FULL);
				mol = $signed({1'b0, pmin_q}); moh = $signed({1'b0, pmax_q});
			end
			MAP_SIDE: begin
				mx  = 13'(deg_q);
				mil = 13'(snem_pkg::SIDE_LIMIT_LOW); mih = 13'(snem_pkg::SIDE_LIMIT_HIGH);
				mol = 13'(snem_pkg::SIDE_OUT_LOW); moh = 13'(snem_pkg::SIDE_OUT_HIGH);
			end
			default: begin
				mx = '0;
			end
		endcase
	end

	assign md     = 14'(mih) - 14'(mil);
	assign mdx    = 14'(mx) - 14'(mil);
	assign mdy    = 14'(moh) - 14'(mol);
	assign md_abs = md[13] ? 14'(-md) : 14'(md);

	logic [37:0]        prod_mag;
	logic signed [25:0] quo_s, map_res, res_cl;
	assign prod_mag = mul_q[37] ? 38'(-mul_q) : 38'(mul_q);
	assign quo_s    = $signed({2'b00, div_quo});
	assign map_res  = (sign_q ? -quo_s : quo_s) + 26'(mol);
	assign res_cl   = (res_q < cl_lo) ? cl_lo : ((res_q > cl_hi) ? cl_hi : res_q);

	logic signed [17:0] side_new_goal;
	assign side_new_goal = $signed({res_q[9:0], 8'd0});

	// operand steering for the shared units
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		div_req = '0;
		case (state_q)
			S_FRAC: begin
				if (ch_q != CH_SIDE && !el_done) begin
					div_req.start    = 1'b1;
					div_req.rem_init = elapsed[16:0];
					div_req.divisor  = cur_span;
					div_req.steps    = snem_pkg::DIV_CW'(snem_pkg::FRAC_STEPS);
				end
			end
			S_SQ: begin
				mul_a = $signed({3'b000, f_q});
				mul_b = $signed({1'b0, f_q});
			end
			S_PROD: begin
				mul_a = 20'(move_dist);
				mul_b = $signed({1'b0, e_q});
			end
			S_MMUL: begin
				mul_a = 20'(mdx);
				mul_b = 18'(mdy);
			end
			S_MDIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_mag[snem_pkg::DIV_QW-1:0];
				div_req.divisor  = snem_pkg::DIV_DW'(md_abs);
				div_req.steps    = snem_pkg::DIV_CW'(snem_pkg::MAP_STEPS);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= CMD_TICK;
			ang_q        <= '0;
			mt_q         <= '0;
			mv_q         <= '0;
			rot_emit_q   <= 1'b0;
			ch_q         <= CH_ROT;
			f_q          <= '0;
			e_q          <= '0;
			up_q         <= 1'b0;
			srv_q        <= SRV_ROT;
			map_sel_q    <= MAP_ROT;
			deg_q        <= '0;
			res_q        <= '0;
			sign_q       <= 1'b0;
			pmin_q       <= 12'd150;
			pmax_q       <= 12'd600;
			rmin_q       <= -9'sd90;
			rmax_q       <= 9'sd90;
			roff_q       <= '0;
			foff_q       <= '0;
			soff_q       <= '0;
			time_now_q   <= '0;
			rot_start_q  <= '0;
			rot_pos_q    <= '0;
			rot_goal_q   <= '0;
			rot_begin_q  <= '0;
			rot_span_q   <= '0;
			fwd_start_q  <= '0;
			fwd_pos_q    <= '0;
			fwd_goal_q   <= '0;
			fwd_begin_q  <= '0;
			fwd_span_q   <= '0;
			side_start_q <= '0;
			side_pos_q   <= '0;
			side_goal_q  <= '0;
			side_frac_q  <= '0;
			out_valid_q  <= 1'b0;
			out_servo_q  <= SRV_ROT;
			out_pulse_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_PULSE_MIN: pmin_q <= cfg_wdata;
					REG_PULSE_MAX: pmax_q <= cfg_wdata;
					REG_ROT_MIN:   rmin_q <= $signed(cfg_wdata[8:0]);
					REG_ROT_MAX:   rmax_q <= $signed(cfg_wdata[8:0]);
					REG_ROT_OFF:   roff_q <= $signed(cfg_wdata[7:0]);
					REG_FWD_OFF:   foff_q <= $signed(cfg_wdata[7:0]);
					REG_SIDE_OFF:  soff_q <= $signed(cfg_wdata[7:0]);
					default: begin
						pmin_q <= pmin_q;
					end
				endcase
			end

			// load the next pulse, or drop the one just taken
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				out_servo_q <= srv_q;
				out_pulse_q <= res_q[11:0];
				out_last_q  <= srv_q == SRV_NECK;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q <= s_tuser;
						ang_q <= $signed(s_tdata[8:0]);
						mt_q  <= s_tdata[24:9];
						if (s_tuser == CMD_TICK) begin
							time_now_q <= s_tdata[56:25];
							mv_q <= {side_pos_q != side_goal_q, fwd_pos_q != fwd_goal_q,
							         rot_pos_q != rot_goal_q};
							rot_emit_q <= rot_pos_q != rot_goal_q;
							state_q    <= S_PICK;
						end else begin
							state_q <= S_SET;
						end
					end
				end
				S_SET: begin
					case (cmd_q)
						CMD_ROT: begin
							if (rgoal != rot_goal_q) begin
								rot_span_q  <= rspan;
								rot_start_q <= rot_pos_q;
								rot_goal_q  <= rgoal;
								rot_begin_q <= time_now_q;
							end
							state_q <= S_IDLE;
						end
						CMD_FWD: begin
							if (fgoal != fwd_goal_q) begin
								fwd_span_q  <= fspan;
								fwd_start_q <= fwd_pos_q;
								fwd_goal_q  <= fgoal;
								fwd_begin_q <= time_now_q;
							end
							state_q <= S_IDLE;
						end
						CMD_SIDE: begin
							deg_q     <= 9'(sdeg);
							map_sel_q <= MAP_SIDE;
							state_q   <= S_MMUL;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_PICK: begin
					// ease every moving axis, then run the pulse outputs
					if (mv_q[0]) begin
						mv_q[0] <= 1'b0; ch_q <= CH_ROT;  state_q <= S_FRAC;
					end else if (mv_q[1]) begin
						mv_q[1] <= 1'b0; ch_q <= CH_FWD;  state_q <= S_FRAC;
					end else if (mv_q[2]) begin
						mv_q[2] <= 1'b0; ch_q <= CH_SIDE; state_q <= S_FRAC;
					end else begin
						srv_q     <= rot_emit_q ? SRV_ROT : SRV_LEFT;
						map_sel_q <= rot_emit_q ? MAP_ROT : MAP_LEFT;
						state_q   <= S_MMUL;
					end
				end
				S_FRAC: begin
					if (ch_q == CH_SIDE) begin
						f_q     <= side_frac_q;
						state_q <= S_SQ;
					end else if (el_done) begin
						f_q     <= 17'(snem_pkg::ONE_Q16);
						state_q <= S_SQ;
					end else begin
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (div_done) begin
						f_q     <= div_quo[16:0];
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					state_q <= S_EASE;
				end
				S_EASE: begin
					e_q     <= ease_v;
					state_q <= S_PROD;
				end
				S_PROD: begin
					up_q    <= up_c;
					state_q <= S_UPD;
				end
				S_UPD: begin
					case (ch_q)
						CH_ROT: rot_pos_q <= new_pos_cl;
						CH_FWD: fwd_pos_q <= new_pos_cl;
						default: begin
							side_pos_q  <= new_pos_cl;
							side_frac_q <= (side_frac_sum > 18'(snem_pkg::ONE_Q16))
							               ? 17'(snem_pkg::ONE_Q16) : side_frac_sum[16:0];
						end
					endcase
					state_q <= S_PICK;
				end
				S_MMUL: begin
					if (md == 14'sd0) begin
						res_q   <= 26'(mol);
						state_q <= S_MDONE;
					end else begin
						state_q <= S_MDIV;
					end
				end
				S_MDIV: begin
					sign_q  <= mul_q[37] ^ md[13];
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (div_done) begin
						res_q   <= map_res;
						state_q <= S_MDONE;
					end
				end
				S_MDONE: begin
					case (map_sel_q)
						MAP_SIDE: begin
							if (side_new_goal != side_goal_q) begin
								side_start_q <= side_pos_q;
								side_goal_q  <= side_new_goal;
								side_frac_q  <= '0;
							end
							state_q <= S_IDLE;
						end
						MAP_PULSE: begin
							state_q <= S_EMIT;
						end
						default: begin
							deg_q     <= 9'(res_cl);
							map_sel_q <= MAP_PULSE;
							state_q   <= S_MMUL;
						end
					endcase
				end
				S_EMIT: begin
					// hold until the output register frees up
					if (out_free) begin
						if (srv_q == SRV_NECK) begin
							state_q <= S_IDLE;
						end else begin
							srv_q     <= srv_q + 2'd1;
							map_sel_q <= {1'b0, srv_q + 2'd1};
							state_q   <= S_MMUL;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_pulse_q};
	assign m_tuser  = out_servo_q;
	assign m_tlast  = out_last_q;

	`SNEM_CHECK(a_div_owner, div_busy, state_q == S_FDIV || state_q == S_MWAIT)
	`SNEM_CHECK(a_side_frac_sat, 1'b1, side_frac_q <= 17'(snem_pkg::ONE_Q16))
	`SNEM_CHECK(a_last_is_neck, m_tvalid && m_tlast, m_tuser == SRV_NECK)
	`SNEM_CHECK_NEXT(a_tick_starts, in_acc && s_tuser == CMD_TICK, state_q == S_PICK)

endmodule

`default_nettype wire
